### design/aack_pkg.sv
package aack_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 14;
  localparam int POS_W       = 4;

  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] STOP_BYTE  = 8'h03;

  // input item kinds
  localparam logic [1:0] KIND_MSG  = 2'd0;
  localparam logic [1:0] KIND_CARD = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // master message types
  localparam logic [7:0] MSG_ALARM  = 8'd1;
  localparam logic [7:0] MSG_ANSWER = 8'd2;

  // result events
  localparam logic [2:0] EV_CONFIRM   = 3'd0;
  localparam logic [2:0] EV_MASTER_OK = 3'd1;
  localparam logic [2:0] EV_CARD_READ = 3'd2;
  localparam logic [2:0] EV_ACK_SENT  = 3'd3;
  localparam logic [2:0] EV_RESEND    = 3'd4;
  localparam logic [2:0] EV_LINK_LOST = 3'd5;
  localparam logic [2:0] EV_BEEP      = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_REPLY_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_RETRY_LIMIT   = 2'd1;
  localparam logic [1:0] REG_BEEP_INTERVAL = 2'd2;

  localparam logic [15:0] RST_REPLY_TIMEOUT = 16'd3000;
  localparam logic [2:0]  RST_RETRY_LIMIT   = 3'd5;
  localparam logic [15:0] RST_BEEP_INTERVAL = 16'd1000;

  localparam logic [2:0] RETRY_MAX = 3'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] msg_type;
    logic       alarm_flag;
    logic [7:0] reader_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] retry_number;
    logic       alarm_state;
    logic       last;
  } out_item_t;

  // results produced by one request, handed to the result queue
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

### design/aack_core.sv
module aack_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  aack_pkg::in_item_t item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output aack_pkg::push_t    push
);
  import aack_pkg::*;

  // configuration
  logic [15:0] reply_timeout_r;
  logic [2:0]  retry_limit_r;
  logic [15:0] beep_interval_r;

  // handshake state
  logic             alarm_on_r, alarm_on_nxt;
  logic             reading_stopped_r, reading_stopped_nxt;
  logic             awaiting_reply_r, awaiting_reply_nxt;
  logic [2:0]       resend_count_r, resend_count_nxt;
  logic [15:0]      reply_timer_r, reply_timer_nxt;
  logic [15:0]      beep_timer_r, beep_timer_nxt;
  logic [POS_W-1:0] frame_pos_r, frame_pos_nxt;
  logic             start_good_r, start_good_nxt;

  logic [2:0]  ev0, ev1;
  logic [1:0]  n;
  logic        good;
  logic        beep;
  logic        timeout;
  logic        may_resend;
  logic [2:0]  ev_reply;
  logic [15:0] bt_inc, rt_inc;

  function automatic logic [15:0] sat16_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // per-request state update and result selection
  always_comb begin
    alarm_on_nxt        = alarm_on_r;
    reading_stopped_nxt = reading_stopped_r;
    awaiting_reply_nxt  = awaiting_reply_r;
    resend_count_nxt    = resend_count_r;
    reply_timer_nxt     = reply_timer_r;
    beep_timer_nxt      = beep_timer_r;
    frame_pos_nxt       = frame_pos_r;
    start_good_nxt      = start_good_r;
    ev0        = EV_CONFIRM;
    ev1        = EV_CONFIRM;
    n          = 2'd0;
    good       = start_good_r && (item.reader_byte == STOP_BYTE);
    bt_inc     = sat16_inc(beep_timer_r);
    rt_inc     = sat16_inc(reply_timer_r);
    beep       = alarm_on_r && (bt_inc >= beep_interval_r);
    timeout    = awaiting_reply_r && (rt_inc > reply_timeout_r);
    may_resend = resend_count_r < retry_limit_r;
    ev_reply   = may_resend ? EV_RESEND : EV_LINK_LOST;

    unique case (item.kind)
      KIND_MSG: begin
        if (item.msg_type == MSG_ALARM) begin
          reading_stopped_nxt = 1'b0;
          alarm_on_nxt        = item.alarm_flag;
          awaiting_reply_nxt  = 1'b0;
          ev0 = EV_CONFIRM;
          n   = 2'd1;
        end else if (item.msg_type == MSG_ANSWER) begin
          awaiting_reply_nxt  = 1'b0;
          reading_stopped_nxt = 1'b0;
          ev0 = EV_MASTER_OK;
          n   = 2'd1;
        end
      end
      KIND_CARD: begin
        if (reading_stopped_r) begin
          frame_pos_nxt  = '0;
          start_good_nxt = 1'b0;
        end else if (frame_pos_r == '0) begin
          start_good_nxt = (item.reader_byte == START_BYTE);
          frame_pos_nxt  = POS_W'(1);
        end else if (frame_pos_r >= POS_W'(FRAME_BYTES - 1)) begin
          frame_pos_nxt  = '0;
          start_good_nxt = 1'b0;
          if (good) begin
            ev0 = EV_CARD_READ;
            n   = 2'd1;
            if (alarm_on_r) begin
              reading_stopped_nxt = 1'b1;
              awaiting_reply_nxt  = 1'b1;
              reply_timer_nxt     = '0;
              resend_count_nxt    = '0;
              ev1 = EV_ACK_SENT;
              n   = 2'd2;
            end
          end
        end else begin
          frame_pos_nxt = frame_pos_r + POS_W'(1);
        end
      end
      KIND_TICK: begin
        beep_timer_nxt  = beep ? 16'd0 : bt_inc;
        reply_timer_nxt = rt_inc;
        if (timeout) begin
          if (resend_count_r != RETRY_MAX) resend_count_nxt = resend_count_r + 3'd1;
          if (may_resend) begin
            reply_timer_nxt = '0;
          end else begin
            reading_stopped_nxt = 1'b0;
            awaiting_reply_nxt  = 1'b0;
            alarm_on_nxt        = 1'b0;
          end
        end
        // beep goes ahead of the reply event
        if (beep && timeout) begin
          ev0 = EV_BEEP;
          ev1 = ev_reply;
          n   = 2'd2;
        end else if (beep) begin
          ev0 = EV_BEEP;
          n   = 2'd1;
        end else if (timeout) begin
          ev0 = ev_reply;
          n   = 2'd1;
        end
      end
      default: begin
        n = 2'd0;
      end
    endcase
  end

  // results carry state after this request
  always_comb begin
    push.cnt                 = fire ? n : 2'd0;
    push.first.event_res     = ev0;
    push.first.retry_number  = resend_count_nxt;
    push.first.alarm_state   = alarm_on_nxt;
    push.first.last          = (n == 2'd1);
    push.second.event_res    = ev1;
    push.second.retry_number = resend_count_nxt;
    push.second.alarm_state  = alarm_on_nxt;
    push.second.last         = 1'b1;
  end

  // config and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_timeout_r   <= RST_REPLY_TIMEOUT;
      retry_limit_r     <= RST_RETRY_LIMIT;
      beep_interval_r   <= RST_BEEP_INTERVAL;
      alarm_on_r        <= 1'b0;
      reading_stopped_r <= 1'b0;
      awaiting_reply_r  <= 1'b0;
      resend_count_r    <= '0;
      reply_timer_r     <= '0;
      beep_timer_r      <= '0;
      frame_pos_r       <= '0;
      start_good_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REPLY_TIMEOUT: reply_timeout_r <= cfg_wdata;
          REG_RETRY_LIMIT:   retry_limit_r   <= cfg_wdata[2:0];
          REG_BEEP_INTERVAL: beep_interval_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (fire) begin
        alarm_on_r        <= alarm_on_nxt;
        reading_stopped_r <= reading_stopped_nxt;
        awaiting_reply_r  <= awaiting_reply_nxt;
        resend_count_r    <= resend_count_nxt;
        reply_timer_r     <= reply_timer_nxt;
        beep_timer_r      <= beep_timer_nxt;
        frame_pos_r       <= frame_pos_nxt;
        start_good_r      <= start_good_nxt;
      end
    end
  end

endmodule

### design/aack_outq.sv
module aack_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  aack_pkg::push_t     push,
  output logic                space2,
  output logic                out_valid,
  input  logic                out_ready,
  output aack_pkg::out_item_t out_data
);
  import aack_pkg::*;

  // four-entry result queue, takes up to two results a cycle
  out_item_t  q_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 3'd0);
  assign out_data  = q_r[rd_ptr_r];
  assign space2    = (count_r <= 3'd2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.cnt;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push.cnt} - {2'b00, pop};
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) q_r[wr_ptr_r] <= push.first;
    if (push.cnt == 2'd2) q_r[wr_ptr_r + 2'd1] <= push.second;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### design/alarm_ack_with_card_retry_top.sv
// Channel  | Direction | Signals                       | Transfer
// ---------+-----------+-------------------------------+-------------------------
// in_      | input     | in_valid, in_ready, in_data   | in_valid && in_ready
// out_     | output    | out_valid, out_ready, out_data| out_valid && out_ready
// cfg_     | input     | cfg_we, cfg_index, cfg_wdata  | cfg_we, no wait
//
// One request per cycle is taken; its zero, one or two results are ready in
// the next cycle from a four-entry queue, one per cycle while out_ready is high.
// in_ready is high while the queue holds two results or fewer, so a stalled
// out_ready holds off requests only once three or more results are waiting.
// Synchronous active-low reset restores register defaults and clears state.
module alarm_ack_with_card_retry_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  aack_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output aack_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import aack_pkg::*;

  push_t push;
  logic  space2;
  logic  fire;

  assign in_ready = space2;
  assign fire     = in_valid && space2;

  // request processing and state
  aack_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push)
  );

  // result queue
  aack_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space2    (space2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
